[src/lmfc_pkg.sv]
// Shared types, constants and round functions for the Lai-Massey/Feistel CTS cipher.
package lmfc_pkg;

    localparam int BYTE_W  = 8;
    localparam int BLK_W   = 32;
    localparam int HALF_W  = 16;
    localparam int NIB_W   = 4;
    localparam int BUF_W   = 2 * BLK_W;
    localparam int CNT_W   = 4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [BLK_W-1:0]  block_t;
    typedef logic [HALF_W-1:0] half_t;
    typedef logic [NIB_W-1:0]  nibble_t;
    typedef logic [CNT_W-1:0]  ocnt_t;

    // Flags that go with a run of result beats in the output buffer
    typedef struct packed {
        logic msg_end;
        logic too_short;
    } run_flags_t;

    localparam nibble_t SBOX [16] = '{
        4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5
    };

    // Key mix, nibble substitution, then bit permutation (5i+9) mod 16, MSB-first
    function automatic half_t round_fn(input half_t x, input half_t k);
        half_t v;
        half_t s;
        half_t p;
        int    dst;
        v = x ^ k;
        for (int i = 0; i < 4; i++) begin
            s[NIB_W*i +: NIB_W] = SBOX[v[NIB_W*i +: NIB_W]];
        end
        for (int i = 0; i < HALF_W; i++) begin
            dst = (5 * i + 9) % HALF_W;
            p[HALF_W-1-dst] = s[HALF_W-1-i];
        end
        return p;
    endfunction

endpackage

[src/lmfc_encrypt.sv]
// Four-round block encryption: two Lai-Massey rounds, two Feistel rounds, half swap.
module lmfc_encrypt (
    input  lmfc_pkg::block_t plain,
    input  lmfc_pkg::block_t key,
    output lmfc_pkg::block_t cipher
);
    import lmfc_pkg::*;

    half_t k0, k1;
    half_t l0, r0, t0;
    half_t l1, r1, t1;
    half_t l2, r2;
    half_t l3, r3;
    half_t l4, r4;

    assign k0 = key[BLK_W-1:HALF_W];
    assign k1 = key[HALF_W-1:0];

    // Lai-Massey rounds: both halves take the same masked term
    always_comb begin
        l0 = plain[BLK_W-1:HALF_W];
        r0 = plain[HALF_W-1:0];
        t0 = round_fn(l0 ^ r0, k0);
        l1 = l0 ^ t0;
        r1 = r0 ^ t0;
        t1 = round_fn(l1 ^ r1, k1);
        l2 = l1 ^ t1;
        r2 = r1 ^ t1;
    end

    // Feistel rounds, then swap halves
    always_comb begin
        l3 = r2;
        r3 = round_fn(r2, k0) ^ l2;
        l4 = r3;
        r4 = round_fn(r3, k1) ^ l3;
        cipher = {r4, l4};
    end

endmodule

[src/lai_massey_feistel_cts_cipher.sv]
// Top level: byte-serial Lai-Massey/Feistel cipher with ciphertext stealing.
// Plaintext bytes enter one per beat with tlast on the final byte of a message;
// they are gathered big-endian into 32-bit blocks and each block is encrypted
// combinationally. The newest ciphertext block is held back and emitted when
// the next block completes, so a partial final block can steal ciphertext from
// it. The block sustains one byte per cycle in and out while m_tready stays
// high: each beat passes an input register, one encryption pass and a 64-bit
// output buffer that drains one byte per accepted output beat. At the end of a
// message up to eight result bytes are queued and input waits while the buffer
// drains. A message under four bytes yields one beat with too_short set and
// zero data. The key must be written through cfg_wr_en/cfg_wr_data only while
// idle; the block itself does not enforce this.
module lai_massey_feistel_cts_cipher (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,   // cipher_key
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,       // [7:0] data_byte
    input  logic                 s_tlast,       // msg_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,       // [7:0] out_byte
    output logic                 m_tlast,       // run_last
    output logic [1:0]           m_tuser        // [0] msg_end, [1] too_short
);
    import lmfc_pkg::*;

    block_t     key_reg;
    logic       in_valid_reg;
    byte_t      in_byte_reg;
    logic       in_last_reg;
    block_t     gather_reg, gather_next;
    logic [1:0] idx_reg, idx_next;
    block_t     held_reg, held_next;
    logic       held_valid_reg, held_valid_next;
    logic [BUF_W-1:0] obuf_reg, obuf_next;
    ocnt_t      ocnt_reg, ocnt_next;
    run_flags_t flags_reg, flags_next;

    block_t     merged;
    block_t     low_mask;
    block_t     enc_in;
    block_t     enc_out;
    logic       complete;
    logic       no_result;
    logic       buf_free;
    logic       consume;
    logic       drain;
    logic       load;
    logic [BUF_W-1:0] load_buf;
    ocnt_t      load_cnt;
    run_flags_t load_flags;

    // Key register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_wr_en) begin
            key_reg <= cfg_wr_data;
        end
    end

    // Output handshake
    assign drain    = m_tvalid && m_tready;
    assign buf_free = (ocnt_reg == '0) || ((ocnt_reg == ocnt_t'(1)) && m_tready);

    // Decide whether the registered byte can be processed this cycle
    assign complete  = (idx_reg == 2'd3);
    assign no_result = !in_last_reg && (!complete || !held_valid_reg);
    assign consume   = in_valid_reg && (no_result || buf_free);
    assign load      = consume && !no_result;
    assign s_tready  = !in_valid_reg || consume;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Place the new byte and pick the stolen low bytes of the held block
    always_comb begin
        case (idx_reg)
            2'd0: begin
                merged   = gather_reg | {in_byte_reg, 24'h0};
                low_mask = 32'h00FF_FFFF;
            end
            2'd1: begin
                merged   = gather_reg | {8'h0, in_byte_reg, 16'h0};
                low_mask = 32'h0000_FFFF;
            end
            2'd2: begin
                merged   = gather_reg | {16'h0, in_byte_reg, 8'h0};
                low_mask = 32'h0000_00FF;
            end
            default: begin
                merged   = gather_reg | {24'h0, in_byte_reg};
                low_mask = 32'h0000_0000;
            end
        endcase
        enc_in = merged | (held_reg & low_mask);
    end

    lmfc_encrypt u_encrypt (
        .plain  (enc_in),
        .key    (key_reg),
        .cipher (enc_out)
    );

    // Build the run of result bytes for this input
    always_comb begin
        load_buf   = {enc_out, held_reg};
        load_cnt   = ocnt_t'(4);
        load_flags = '{msg_end: in_last_reg, too_short: 1'b0};
        if (complete) begin
            if (held_valid_reg) begin
                load_buf = {held_reg, enc_out};
                load_cnt = in_last_reg ? ocnt_t'(8) : ocnt_t'(4);
            end
        end else if (held_valid_reg) begin
            load_cnt = ocnt_t'(5) + ocnt_t'(idx_reg);
        end else begin
            load_buf             = '0;
            load_cnt             = ocnt_t'(1);
            load_flags.too_short = 1'b1;
        end
    end

    // Gather and hold state
    always_comb begin
        gather_next     = gather_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        if (consume) begin
            if (complete || in_last_reg) begin
                gather_next     = '0;
                idx_next        = 2'd0;
                held_next       = (complete && !in_last_reg) ? enc_out : '0;
                held_valid_next = complete && !in_last_reg;
            end else begin
                gather_next = merged;
                idx_next    = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gather_reg     <= '0;
            idx_reg        <= 2'd0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            gather_reg     <= gather_next;
            idx_reg        <= idx_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // Output buffer: load a run, else shift out one byte per beat
    always_comb begin
        obuf_next  = obuf_reg;
        ocnt_next  = ocnt_reg;
        flags_next = flags_reg;
        if (load) begin
            obuf_next  = load_buf;
            ocnt_next  = load_cnt;
            flags_next = load_flags;
        end else if (drain) begin
            obuf_next = {obuf_reg[BUF_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            ocnt_next = ocnt_reg - ocnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg  <= '0;
            flags_reg <= '0;
        end else begin
            ocnt_reg  <= ocnt_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        obuf_reg <= obuf_next;
    end

    assign m_tvalid   = (ocnt_reg != '0);
    assign m_tdata    = obuf_reg[BUF_W-1 -: BYTE_W];
    assign m_tlast    = (ocnt_reg == ocnt_t'(1));
    assign m_tuser[0] = flags_reg.msg_end && m_tlast;
    assign m_tuser[1] = flags_reg.too_short;

endmodule

[src/lmfc_checker.sv]
// Port-level checks for the cipher top level, with the bind that attaches them.
module lmfc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // Message end closes the run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("message end without run end");

    // Short-message flag is a lone zero beat that ends the message
    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tuser[0] && (m_tdata == 8'h00))
        else $error("malformed short-message beat");

endmodule

bind lai_massey_feistel_cts_cipher lmfc_checker u_lmfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
